### design/ri_pkg.sv
`timescale 1ns / 1ps
// ri_pkg: shared constants and types for the ramp interpolator.
// No dependencies.
package ri_pkg;
    localparam int VALUE_WIDTH_DEF    = 16;
    localparam int POSITION_WIDTH_DEF = 32;

    typedef enum logic
    {
        CMD_LINEAR = 1'b0,
        CMD_QUAD   = 1'b1
    } cmd_t;

    // per-transaction control that travels alongside the divider chain
    typedef struct packed
    {
        logic valid;
        logic bypass;
        logic down;
    } ctl_t;
endpackage

### design/ri_div_cell.sv
`timescale 1ns / 1ps
// ri_div_cell: one restoring-division step of the divider chain.
// Depends on ri_pkg.
module ri_div_cell #(
    parameter int NW = 64,
    parameter int DW = 64,
    parameter int VW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ri_pkg::ctl_t   ctl_in,
    input  logic [NW-1:0]  num_in,
    input  logic [DW-1:0]  den_in,
    input  logic [DW:0]    rem_in,
    input  logic [NW-1:0]  quo_in,
    input  logic [VW-1:0]  base_in,
    output ri_pkg::ctl_t   ctl_out,
    output logic [NW-1:0]  num_out,
    output logic [DW-1:0]  den_out,
    output logic [DW:0]    rem_out,
    output logic [NW-1:0]  quo_out,
    output logic [VW-1:0]  base_out
);
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          take;
    ri_pkg::ctl_t  ctl_reg;
    logic [NW-1:0] num_reg, quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [VW-1:0] base_reg;

    assign shifted = {rem_in[DW-1:0], num_in[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_in};
    assign take    = !diff[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= {num_in[NW-2:0], 1'b0};
        den_reg  <= den_in;
        rem_reg  <= take ? diff[DW:0] : shifted;
        quo_reg  <= {quo_in[NW-2:0], take};
        base_reg <= base_in;
    end

    assign ctl_out  = ctl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign base_out = base_reg;
endmodule

### design/ri_front.sv
`timescale 1ns / 1ps
// ri_front: operand preparation; products and divisor, three registered stages.
// Depends on ri_pkg.
module ri_front #(
    parameter int VW = 16,
    parameter int PW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              command,
    input  logic [VW-1:0]     start_value,
    input  logic [VW-1:0]     end_value,
    input  logic [PW-1:0]     ramp_position,
    input  logic [PW-1:0]     ramp_length,
    output ri_pkg::ctl_t      ctl,
    output logic [VW+2*PW-1:0] num,
    output logic [2*PW-1:0]   den,
    output logic [VW-1:0]     base
);
    localparam int NW = VW + 2 * PW;
    ri_pkg::ctl_t  c1_reg, c2_reg, c3_reg;
    logic          q1_reg, q2_reg;
    logic [VW+PW-1:0] dp_reg, dp2_reg;
    logic [PW-1:0] pos_reg, len_reg;
    logic [VW-1:0] base1_reg, base2_reg, base3_reg;
    logic [2*PW-1:0] plo_reg;
    logic [VW+PW-1:0] phi_reg;
    logic [NW-1:0] num_reg;
    logic [2*PW-1:0] den2_reg, den_reg;
    logic [VW-1:0] mag;
    logic          down, bypass;
    logic [VW-1:0] bval;

    assign down   = end_value < start_value;
    assign mag    = down ? start_value - end_value : end_value - start_value;
    assign bypass = (ramp_length == '0) || (ramp_position == '0)
                    || (ramp_position >= ramp_length);
    assign bval   = ((ramp_length == '0) || (ramp_position == '0))
                    ? start_value : (bypass ? end_value : start_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            c1_reg <= '{valid: go, bypass: bypass, down: down};
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    // stage 1: mag*pos; stage 2: partial products of (mag*pos)*pos, and len^2 or len;
    // stage 3: sum of the partial products or the linear scale
    always_ff @(posedge clk)
    begin
        q1_reg    <= command == ri_pkg::CMD_QUAD;
        dp_reg    <= {{PW{1'b0}}, mag} * {{VW{1'b0}}, ramp_position};
        pos_reg   <= ramp_position;
        len_reg   <= ramp_length;
        base1_reg <= bval;

        q2_reg    <= q1_reg;
        dp2_reg   <= dp_reg;
        plo_reg   <= {{PW{1'b0}}, dp_reg[PW-1:0]} * {{PW{1'b0}}, pos_reg};
        phi_reg   <= {{PW{1'b0}}, dp_reg[VW+PW-1:PW]} * {{VW{1'b0}}, pos_reg};
        if (q1_reg)
            den2_reg <= {{PW{1'b0}}, len_reg} * {{PW{1'b0}}, len_reg};
        else
            den2_reg <= {{PW{1'b0}}, len_reg};
        base2_reg <= base1_reg;

        if (q2_reg)
            num_reg <= {{VW{1'b0}}, plo_reg} + {phi_reg, {PW{1'b0}}};
        else
            num_reg <= {{PW{1'b0}}, dp2_reg};
        den_reg   <= den2_reg;
        base3_reg <= base2_reg;
    end

    assign ctl  = c3_reg;
    assign num  = num_reg;
    assign den  = den_reg;
    assign base = base3_reg;
endmodule

### design/ramp_interpolator.sv
`timescale 1ns / 1ps
// ramp_interpolator: top level; operand front end and a chain of divider cells.
// Depends on ri_pkg, ri_front, ri_div_cell.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   busy is tied low: one transaction may enter every cycle.
//   command selects linear (0) or quadratic ease-in (1) interpolation
//   between start_value and end_value at ramp_position of ramp_length.
//   The result appears on interpolated_value with done high for one cycle.
//   Before done rises, the result passes three operand stages, one restoring
//   division cell per quotient bit and the output register.
//   Throughput: one transaction per cycle.
//   Reset clears all valid flags; nothing is in flight afterwards.
//   The receiver cannot stall; results are presented once and not held.
module ramp_interpolator #(
    parameter int VALUE_WIDTH    = ri_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = ri_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [VALUE_WIDTH-1:0]    start_value,
    input  logic [VALUE_WIDTH-1:0]    end_value,
    input  logic [POSITION_WIDTH-1:0] ramp_position,
    input  logic [POSITION_WIDTH-1:0] ramp_length,
    output logic                      done,
    output logic [VALUE_WIDTH-1:0]    interpolated_value
);
    localparam int VW = VALUE_WIDTH;
    localparam int DW = 2 * POSITION_WIDTH;
    localparam int NW = VW + DW;

    ri_pkg::ctl_t  ctl [NW+1];
    logic [NW-1:0] num [NW+1];
    logic [DW-1:0] den [NW+1];
    logic [DW:0]   rem [NW+1];
    logic [NW-1:0] quo [NW+1];
    logic [VW-1:0] base[NW+1];
    logic          done_reg;
    logic [VW-1:0] val_reg;
    logic [VW-1:0] step;

    assign busy = 1'b0;

    ri_front #(.VW(VW), .PW(POSITION_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .go(start && !busy), .command(command),
        .start_value(start_value), .end_value(end_value),
        .ramp_position(ramp_position), .ramp_length(ramp_length),
        .ctl(ctl[0]), .num(num[0]), .den(den[0]), .base(base[0])
    );
    assign rem[0] = '0;
    assign quo[0] = '0;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        ri_div_cell #(.NW(NW), .DW(DW), .VW(VW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .ctl_in(ctl[i]), .num_in(num[i]), .den_in(den[i]),
            .rem_in(rem[i]), .quo_in(quo[i]), .base_in(base[i]),
            .ctl_out(ctl[i+1]), .num_out(num[i+1]), .den_out(den[i+1]),
            .rem_out(rem[i+1]), .quo_out(quo[i+1]), .base_out(base[i+1])
        );
    end

    assign step = quo[NW][VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl[NW].valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl[NW].bypass)
            val_reg <= base[NW];
        else if (ctl[NW].down)
            val_reg <= base[NW] - step;
        else
            val_reg <= base[NW] + step;
    end

    assign done               = done_reg;
    assign interpolated_value = val_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[NW].valid |=> done)
        else $error("result strobe lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl[NW].valid |=> !done)
        else $error("spurious result strobe");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
endmodule
